@@ rtl/ctw_pkg.sv @@
// shared constants, types and helpers for the text console writer
// depends on nothing; imported by every module of the block
package ctw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 23;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int ADDR_W  = $clog2(CELLS);

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BLANK = 8'h20;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // commands from the sequencer to the line map
    typedef struct packed {
        logic             clear;
        logic             scroll;
        logic             mark;
        logic [ROW_W-1:0] mark_row;
    } map_cmd_t;

    // physical line numbers and line valid flags back to the sequencer
    typedef struct packed {
        logic [ROW_W-1:0] cur_phys;
        logic             cur_valid;
        logic [ROW_W-1:0] rd_phys;
        logic             rd_valid;
    } map_stat_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

@@ rtl/ctw_char_ram.sv @@
// character store: one write port, one read port with registered data
// depends on ctw_pkg
module ctw_char_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ctw_pkg::ADDR_W-1:0] waddr,
    input  logic [7:0]                wdata,
    input  logic                      re,
    input  logic [ctw_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                rdata
);
    import ctw_pkg::*;

    logic [7:0] char_mem [CELLS];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            char_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= char_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ctw_line_map.sv @@
// line map: rotating top-line pointer and one valid flag per physical line
// depends on ctw_pkg
module ctw_line_map (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctw_pkg::map_cmd_t        cmd,
    input  logic [ctw_pkg::ROW_W-1:0] cur_row,
    input  logic [ctw_pkg::ROW_W-1:0] rd_row,
    output ctw_pkg::map_stat_t       stat
);
    import ctw_pkg::*;

    logic [ROW_W-1:0] top_reg;
    logic [ROW_W-1:0] top_next;
    logic [ROWS-1:0]  row_valid_reg;
    logic [ROWS-1:0]  row_valid_next;

    function automatic logic [ROW_W-1:0] to_phys(input logic [ROW_W-1:0] lrow,
                                                 input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= (ROW_W+1)'(ROWS))
        begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        to_phys = sum[ROW_W-1:0];
    endfunction

    always_comb
    begin
        stat.cur_phys  = to_phys(cur_row, top_reg);
        stat.rd_phys   = to_phys(rd_row, top_reg);
        stat.cur_valid = (int'(stat.cur_phys) < ROWS) ? row_valid_reg[stat.cur_phys] : 1'b0;
        stat.rd_valid  = (int'(stat.rd_phys) < ROWS) ? row_valid_reg[stat.rd_phys] : 1'b0;
    end

    always_comb
    begin
        top_next       = top_reg;
        row_valid_next = row_valid_reg;
        if (cmd.clear)
        begin
            top_next       = '0;
            row_valid_next = '0;
        end
        else
        begin
            // the old top line comes back as the blank bottom line
            if (cmd.scroll)
            begin
                row_valid_next[top_reg] = 1'b0;
                top_next = (top_reg == ROW_LAST) ? '0 : top_reg + 1'b1;
            end
            if (cmd.mark)
            begin
                row_valid_next[cmd.mark_row] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            top_reg       <= top_next;
            row_valid_reg <= row_valid_next;
        end
    end

endmodule

@@ rtl/text_console_writer_unit.sv @@
// text console writer: request sequencer and cursor, top level
// depends on ctw_pkg, ctw_char_ram, ctw_line_map
//
// A request is taken at a rising edge with start high and busy low: action,
// char_code, read_row and read_col. Exactly one result follows, shown for one
// cycle with done high: cell_char, cursor_line, cursor_column and scrolled.
// The receiver cannot hold results off, and none is needed: busy stays high
// until the result is out, and the next request may be taken in the very
// cycle that done is high.
// A put, newline, clear or the unused action ends in the execute step; a read
// of a valid line goes on to the read-return step, set by the registered read
// port of the character store.
// Scrolling moves a top-line pointer and marks the recycled line blank; clear
// marks every line blank. The first character put on a blank line first
// fills that line with spaces, one cell per cycle, then repeats the execute
// step; a read of a blank line returns a space without touching memory.
// Reset clears the cursor, the top-line pointer and the line flags at once,
// so no clearing pass runs and the block takes requests right after reset.
module text_console_writer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] action,
    input  logic [7:0] char_code,
    input  logic [4:0] read_row,
    input  logic [6:0] read_col,
    output logic       done,
    output logic [7:0] cell_char,
    output logic [4:0] cursor_line,
    output logic [6:0] cursor_column,
    output logic       scrolled
);
    import ctw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_READ
    } state_t;

    state_t           state_reg, state_next;
    action_t          action_reg, action_next;
    logic [7:0]       code_reg, code_next;
    logic [4:0]       rrow_reg, rrow_next;
    logic [6:0]       rcol_reg, rcol_next;
    logic [ROW_W-1:0] cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0] cursor_col_reg, cursor_col_next;
    logic [COL_W-1:0] fill_col_reg, fill_col_next;
    logic             done_reg, done_next;
    logic [7:0]       cell_reg, cell_next;
    logic             scrolled_reg, scrolled_next;

    map_cmd_t         cmd;
    map_stat_t        stat;
    logic             mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]       mem_rdata;

    logic             is_newline;
    logic             put_char;
    logic             need_next;
    logic             rd_in_range;

    ctw_char_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ctw_line_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .cur_row (cursor_row_reg),
        .rd_row  (ROW_W'(rrow_reg)),
        .stat    (stat)
    );

    assign is_newline  = (code_reg == CH_LF) || (code_reg == CH_CR);
    assign put_char    = !is_newline && (code_reg != CH_NUL);
    assign need_next   = is_newline || (put_char && (cursor_col_reg == COL_LAST));
    assign rd_in_range = (int'(rrow_reg) < ROWS) && (int'(rcol_reg) < COLUMNS);

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        code_next       = code_reg;
        rrow_next       = rrow_reg;
        rcol_next       = rcol_reg;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        fill_col_next   = fill_col_reg;
        done_next       = 1'b0;
        cell_next       = cell_reg;
        scrolled_next   = scrolled_reg;
        cmd             = '0;
        mem_we          = 1'b0;
        mem_waddr       = cell_addr(stat.cur_phys, cursor_col_reg);
        mem_wdata       = code_reg;
        mem_re          = 1'b0;
        mem_raddr       = cell_addr(stat.rd_phys, COL_W'(rcol_reg));

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    action_next = action_t'(action);
                    code_next   = char_code;
                    rrow_next   = read_row;
                    rcol_next   = read_col;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                cell_next     = '0;
                scrolled_next = 1'b0;
                case (action_reg)
                    ACT_PUT:
                    begin
                        if (put_char && !stat.cur_valid)
                        begin
                            // blank line: fill it with spaces before the write
                            fill_col_next = '0;
                            state_next    = S_FILL;
                        end
                        else
                        begin
                            mem_we = put_char;
                            if (need_next)
                            begin
                                cursor_col_next = '0;
                                if (cursor_row_reg == ROW_LAST)
                                begin
                                    cmd.scroll    = 1'b1;
                                    scrolled_next = 1'b1;
                                end
                                else
                                begin
                                    cursor_row_next = cursor_row_reg + 1'b1;
                                end
                            end
                            else if (put_char)
                            begin
                                cursor_col_next = cursor_col_reg + 1'b1;
                            end
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end

                    ACT_READ:
                    begin
                        if (rd_in_range && stat.rd_valid)
                        begin
                            mem_re     = 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            cell_next  = rd_in_range ? CH_BLANK : 8'h00;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end

                    ACT_CLEAR:
                    begin
                        cmd.clear       = 1'b1;
                        cursor_row_next = '0;
                        cursor_col_next = '0;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end

                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(stat.cur_phys, fill_col_reg);
                mem_wdata = CH_BLANK;
                if (fill_col_reg == COL_LAST)
                begin
                    cmd.mark     = 1'b1;
                    cmd.mark_row = stat.cur_phys;
                    state_next   = S_EXEC;
                end
                else
                begin
                    fill_col_next = fill_col_reg + 1'b1;
                end
            end

            S_READ:
            begin
                cell_next  = mem_rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            done_reg       <= 1'b0;
            scrolled_reg   <= 1'b0;
            cell_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            done_reg       <= done_next;
            scrolled_reg   <= scrolled_next;
            cell_reg       <= cell_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        code_reg     <= code_next;
        rrow_reg     <= rrow_next;
        rcol_reg     <= rcol_next;
        fill_col_reg <= fill_col_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign cell_char     = cell_reg;
    assign cursor_line   = 5'(cursor_row_reg);
    assign cursor_column = 7'(cursor_col_reg);
    assign scrolled      = scrolled_reg;

`ifndef ASSERT_OFF
    // a result only ever follows the execute or read-return step
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_EXEC || $past(state_reg) == S_READ))
        else $error("result strobe without a finishing step");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_EXEC))
        else $error("accepted request did not enter execute");

    // a scroll leaves the cursor at the start of the bottom line
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && scrolled_reg) |-> (cursor_row_reg == ROW_LAST && cursor_col_reg == '0))
        else $error("scroll left cursor off the bottom line start");

    a_fill_blank_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> !stat.cur_valid)
        else $error("fill running on a line already valid");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_col_reg <= COL_LAST) && (cursor_row_reg <= ROW_LAST))
        else $error("cursor out of range");
`endif

endmodule
